// ===== design/edel_pkg.sv =====
`default_nettype none
package edel_pkg;

  // Header and code geometry
  localparam int unsigned MAGIC_LEN = 4;
  localparam int unsigned CODE_W    = 15;  // longest delta code of 1..256
  localparam int unsigned LEN_W     = 4;   // holds 1..15
  localparam int unsigned PEND_W    = 7;   // bits carried between items
  localparam int unsigned ACC_W     = 22;  // carried bits plus one code
  localparam int unsigned CNT_W     = 5;   // holds 0..22
  localparam int unsigned QDEPTH    = 2;

  // Magic header bytes
  localparam logic [7:0] MAGIC_0 = 8'h45;  // 'E'
  localparam logic [7:0] MAGIC_1 = 8'h44;  // 'D'
  localparam logic [7:0] MAGIC_2 = 8'h45;  // 'E'
  localparam logic [7:0] MAGIC_3 = 8'h4C;  // 'L'

  // One classified item: packed code bits (first bit in bit 0) and length
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
    logic              last;
  } edel_code_t;

  function automatic logic [7:0] magic_byte(input logic [1:0] idx);
    logic [7:0] b;
    unique case (idx)
      2'd0:    b = MAGIC_0;
      2'd1:    b = MAGIC_1;
      2'd2:    b = MAGIC_2;
      default: b = MAGIC_3;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== design/edel_front.sv =====
`default_nettype none
module edel_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_push,
  output logic                     in_full,
  input  wire logic [7:0]          in_data_byte,
  input  wire logic                in_stream_end,
  output logic                     q_push,
  input  wire logic                q_full,
  output edel_pkg::edel_code_t     q_data
);

  logic                 fv_r;
  logic                 fv_nxt;
  edel_pkg::edel_code_t fd_r;
  edel_pkg::edel_code_t fd_nxt;
  logic                 take;

  // Delta code of v = byte + 1, built as an MSB-first string then reversed
  always_comb begin
    logic [8:0]                     v;
    logic [3:0]                     k;
    logic [3:0]                     m;
    logic [1:0]                     l;
    logic [edel_pkg::CODE_W-1:0]    s;
    logic [edel_pkg::CODE_W-1:0]    r;
    logic [edel_pkg::CODE_W-1:0]    mask;
    logic [edel_pkg::LEN_W-1:0]     n;
    v = {1'b0, in_data_byte} + 9'd1;
    priority if (v[8]) k = 4'd8;
    else if (v[7])     k = 4'd7;
    else if (v[6])     k = 4'd6;
    else if (v[5])     k = 4'd5;
    else if (v[4])     k = 4'd4;
    else if (v[3])     k = 4'd3;
    else if (v[2])     k = 4'd2;
    else if (v[1])     k = 4'd1;
    else               k = 4'd0;
    m = k + 4'd1;
    priority if (m[3]) l = 2'd3;
    else if (m[2])     l = 2'd2;
    else if (m[1])     l = 2'd1;
    else               l = 2'd0;
    // gamma(m) is l zeros then m in l+1 bits; the zeros are implicit above s
    mask = (edel_pkg::CODE_W'(1) << k) - edel_pkg::CODE_W'(1);
    s    = (edel_pkg::CODE_W'(m) << k) | (edel_pkg::CODE_W'(v) & mask);
    n    = {1'b0, l, 1'b0} + 4'd1 + k;
    for (int i = 0; i < edel_pkg::CODE_W; i++) begin
      r[i] = s[edel_pkg::CODE_W-1-i];
    end
    fd_nxt.code = r >> (4'(edel_pkg::CODE_W) - n);
    fd_nxt.len  = n;
    fd_nxt.last = in_stream_end;
  end

  // Single holding stage in front of the queue
  assign in_full = fv_r & q_full;
  assign take    = in_push & ~in_full;
  assign q_push  = fv_r & ~q_full;
  assign q_data  = fd_r;

  always_comb begin
    fv_nxt = fv_r;
    if (take) begin
      fv_nxt = 1'b1;
    end else if (q_push) begin
      fv_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fd_r <= fd_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== design/edel_queue.sv =====
`default_nettype none
module edel_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire edel_pkg::edel_code_t wdata,
  output logic                     full,
  input  wire logic                pop,
  output logic                     not_empty,
  output edel_pkg::edel_code_t     rdata
);

  edel_pkg::edel_code_t mem_r [edel_pkg::QDEPTH];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic       do_wr;
  logic       do_rd;

  assign full      = (cnt_r == 2'(edel_pkg::QDEPTH));
  assign not_empty = (cnt_r != 2'd0);
  assign do_wr     = push & ~full;
  assign do_rd     = pop & not_empty;
  assign rdata     = mem_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ do_wr;
    rd_ptr_nxt = rd_ptr_r ^ do_rd;
    cnt_nxt    = cnt_r + 2'(do_wr) - 2'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== design/edel_back.sv =====
`default_nettype none
module edel_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  input  wire edel_pkg::edel_code_t q_data,
  output logic                     q_pop,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic [7:0]               out_byte,
  output logic                     out_run_last,
  output logic                     out_stream_done
);

  // Current item: accumulated bits (carry from earlier items in the low bits)
  logic [edel_pkg::ACC_W-1:0] bits_r, bits_nxt;
  logic [edel_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic                       last_r, last_nxt;
  logic                       hdr_act_r, hdr_act_nxt;
  logic [1:0]                 hdr_idx_r, hdr_idx_nxt;
  logic                       hs_r, hs_nxt;

  // Output register
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       orl_r, orl_nxt;
  logic       osd_r, osd_nxt;

  logic slot_free;
  logic need_emit;

  assign slot_free = ~ov_r | out_pop;
  assign need_emit = hdr_act_r | (cnt_r >= edel_pkg::CNT_W'(8)) |
                     (last_r & (cnt_r != '0));
  assign q_pop     = ~need_emit & q_valid;

  // Emission sequencer: header, then full bytes, then the padded tail
  always_comb begin
    logic [edel_pkg::CNT_W-1:0] rem;
    logic                       more;
    bits_nxt    = bits_r;
    cnt_nxt     = cnt_r;
    last_nxt    = last_r;
    hdr_act_nxt = hdr_act_r;
    hdr_idx_nxt = hdr_idx_r;
    hs_nxt      = hs_r;
    ov_nxt      = ov_r & ~out_pop;
    ob_nxt      = ob_r;
    orl_nxt     = orl_r;
    osd_nxt     = osd_r;
    rem         = '0;
    more        = 1'b0;
    if (q_pop) begin
      // load: merge new code above the carried bits
      bits_nxt    = edel_pkg::ACC_W'(bits_r[edel_pkg::PEND_W-1:0]) |
                    (edel_pkg::ACC_W'(q_data.code) << cnt_r[2:0]);
      cnt_nxt     = cnt_r + edel_pkg::CNT_W'(q_data.len);
      last_nxt    = q_data.last;
      hdr_act_nxt = ~hs_r;
      hdr_idx_nxt = 2'd0;
      hs_nxt      = ~q_data.last;
    end else if (need_emit && slot_free) begin
      ov_nxt = 1'b1;
      if (hdr_act_r) begin
        ob_nxt      = edel_pkg::magic_byte(hdr_idx_r);
        hdr_idx_nxt = hdr_idx_r + 2'd1;
        hdr_act_nxt = (hdr_idx_r != 2'(edel_pkg::MAGIC_LEN - 1));
        more        = hdr_act_nxt | (cnt_r >= edel_pkg::CNT_W'(8)) |
                      (last_r & (cnt_r != '0));
      end else begin
        ob_nxt   = bits_r[7:0];
        bits_nxt = bits_r >> 8;
        rem      = (cnt_r >= edel_pkg::CNT_W'(8)) ? cnt_r - edel_pkg::CNT_W'(8) : '0;
        cnt_nxt  = rem;
        more     = (rem >= edel_pkg::CNT_W'(8)) | (last_r & (rem != '0));
      end
      orl_nxt = ~more;
      osd_nxt = ~more & last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r    <= '0;
      cnt_r     <= '0;
      last_r    <= 1'b0;
      hdr_act_r <= 1'b0;
      hdr_idx_r <= 2'd0;
      hs_r      <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      bits_r    <= bits_nxt;
      cnt_r     <= cnt_nxt;
      last_r    <= last_nxt;
      hdr_act_r <= hdr_act_nxt;
      hdr_idx_r <= hdr_idx_nxt;
      hs_r      <= hs_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ob_r  <= ob_nxt;
    orl_r <= orl_nxt;
    osd_r <= osd_nxt;
  end

  assign out_empty       = ~ov_r;
  assign out_byte        = ob_r;
  assign out_run_last    = orl_r;
  assign out_stream_done = osd_r;

endmodule
`default_nettype wire

// ===== design/elias_delta_byte_encoder.sv =====
`default_nettype none
// Channel   Transfer when        Payload
// input     in_push & ~in_full   in_data_byte[7:0], in_stream_end
// result    out_pop & ~out_empty out_byte[7:0], out_run_last, out_stream_done
//
// Each item is loaded into the back end, which then emits its result bytes
// (up to 4 header bytes and 3 code bytes) through the single-byte output
// register before it takes the next item.
// Reset (rst_n low, synchronous) empties the front stage, queue and output
// register and clears the carried bits and the header flag.
// Input and result sides stall independently through the 2-entry queue.
module elias_delta_byte_encoder (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_data_byte,
  input  wire logic       in_stream_end,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [7:0]      out_byte,
  output logic            out_run_last,
  output logic            out_stream_done
);

  edel_pkg::edel_code_t f2q_data;
  edel_pkg::edel_code_t q2b_data;
  logic f2q_push;
  logic q_full;
  logic q_valid;
  logic q_pop;

  // Classify bytes into delta codes
  edel_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_data_byte  (in_data_byte),
    .in_stream_end (in_stream_end),
    .q_push        (f2q_push),
    .q_full        (q_full),
    .q_data        (f2q_data)
  );

  // Decoupling queue
  edel_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f2q_push),
    .wdata     (f2q_data),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rdata     (q2b_data)
  );

  // Pack bits and emit bytes
  edel_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_data          (q2b_data),
    .q_pop           (q_pop),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done)
  );

endmodule
`default_nettype wire
